@@ hw/rtl/sapq_pkg.sv @@
// Shared constants for the sorted-array priority queue.
`timescale 1ns / 1ps

package sapq_pkg;

  // Default sizes
  localparam int DEPTH_DEF         = 64;
  localparam int PRIORITY_BITS_DEF = 8;

  // Fixed port widths
  localparam int VALUE_W      = 8;
  localparam int PRI_PORT_W   = 8;
  localparam int STATUS_W     = 2;
  localparam int COUNT_PORT_W = 7;

  // Operation codes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

endpackage

@@ hw/rtl/sapq_ram.sv @@
// Simple dual-port entry memory: one write, one registered read per cycle.
`timescale 1ns / 1ps

module sapq_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 16,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/sorted_array_priority_queue.sv @@
// Top level of the sorted-array priority queue.
// Usage:
//   Requests enter on in_valid/in_stall with operation (0 enqueue, 1 dequeue),
//   item_value and item_priority. Each request gives exactly one result on
//   out_valid/out_stall: status, removed entry, new head entry and count.
//   Entries live in a ring buffer in one memory (one write, one read port,
//   registered read), kept in ascending priority order from the head.
// Operation:
//   Dequeue: the result waits for the read of the next head entry (not
//   needed when the queue empties or is empty).
//   Enqueue: each stored entry whose priority is greater than or equal to
//   the new one is read and written back one place later, one entry per
//   cycle on the memory port, before the new entry is written.
//   Full enqueue (overflow) and empty-queue enqueue need no memory read.
//   One request is in flight at a time; in_stall is high from accept until
//   the result is loaded into the output register, so the next request can
//   be taken the cycle after that while the result still waits.
// Reset: rst clears the count and ring pointers; the queue is empty at once.
// Stall: while out_stall holds a result, the next request may be accepted,
//   but its result is held back (the engine waits) until the slot frees.
module sorted_array_priority_queue #(
  parameter int DEPTH         = sapq_pkg::DEPTH_DEF,
  parameter int PRIORITY_BITS = sapq_pkg::PRIORITY_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              operation,
  input  logic [sapq_pkg::VALUE_W-1:0]      item_value,
  input  logic [sapq_pkg::PRI_PORT_W-1:0]   item_priority,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sapq_pkg::STATUS_W-1:0]     status,
  output logic [sapq_pkg::VALUE_W-1:0]      removed_value,
  output logic [sapq_pkg::PRI_PORT_W-1:0]   removed_priority,
  output logic [sapq_pkg::VALUE_W-1:0]      head_value,
  output logic [sapq_pkg::PRI_PORT_W-1:0]   head_priority,
  output logic [sapq_pkg::COUNT_PORT_W-1:0] entry_count
);

  import sapq_pkg::*;

  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int PRI_W   = PRIORITY_BITS;
  localparam int ENTRY_W = VALUE_W + PRI_W;
  localparam int WIDE_W  = (PRI_W > PRI_PORT_W) ? PRI_W : PRI_PORT_W;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0]  ONE_CNT   = CNT_W'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_INS,
    S_DEQ
  } state_t;

  function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] a);
    return (a == LAST_ADDR) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] ptr_dec(input logic [ADDR_W-1:0] a);
    return (a == '0) ? LAST_ADDR : a - 1'b1;
  endfunction

  function automatic logic [PRI_PORT_W-1:0] pri_to_port(input logic [PRI_W-1:0] p);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(p);
    return w[PRI_PORT_W-1:0];
  endfunction

  state_t state;

  // request held for the whole operation
  logic               req_op;
  logic [VALUE_W-1:0] req_val;
  logic [PRI_W-1:0]   req_pri;

  // ring bookkeeping
  logic [CNT_W-1:0]  count;
  logic [ADDR_W-1:0] hptr;
  logic [ADDR_W-1:0] tptr;
  logic [ADDR_W-1:0] rd_ptr;
  logic [ADDR_W-1:0] wr_ptr;
  logic [CNT_W-1:0]  k;        // logical slot being filled during a scan

  // head entry copy and dequeued entry
  logic [VALUE_W-1:0] head_val;
  logic [PRI_W-1:0]   head_pri;
  logic [VALUE_W-1:0] rem_val;
  logic [PRI_W-1:0]   rem_pri;

  // memory port
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;
  logic [VALUE_W-1:0] rd_val;
  logic [PRI_W-1:0]   rd_pri;

  logic [WIDE_W-1:0] in_pri_wide;
  logic [PRI_W-1:0]  in_pri;

  logic               out_free;
  logic               shift_hit;
  logic               finish;
  logic [STATUS_W-1:0] res_status;
  logic [VALUE_W-1:0] res_rem_val;
  logic [PRI_W-1:0]   res_rem_pri;
  logic [VALUE_W-1:0] res_head_val;
  logic [PRI_W-1:0]   res_head_pri;
  logic [CNT_W-1:0]   res_count;

  assign in_pri_wide = WIDE_W'(item_priority);
  assign in_pri      = in_pri_wide[PRI_W-1:0];

  assign rd_val = mem_rdata[ENTRY_W-1:PRI_W];
  assign rd_pri = mem_rdata[PRI_W-1:0];

  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign shift_hit = (req_pri <= rd_pri);

  sapq_ram #(
    .DEPTH  (DEPTH),
    .WIDTH  (ENTRY_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // memory accesses per state
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_ptr;
    mem_wdata = {req_val, req_pri};
    mem_re    = 1'b0;
    mem_raddr = rd_ptr;
    case (state)
      S_START: begin
        if (req_op == OP_ENQ) begin
          if (count == '0) begin
            mem_we    = out_free;
            mem_waddr = tptr;
          end else if (count != FULL_CNT) begin
            mem_re    = 1'b1;
            mem_raddr = ptr_dec(tptr);
          end
        end else if (count > ONE_CNT) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_inc(hptr);
        end
      end
      S_SCAN: begin
        if (shift_hit) begin
          // move entry one place toward the tail
          mem_we    = 1'b1;
          mem_wdata = mem_rdata;
          if (k != ONE_CNT) begin
            mem_re    = 1'b1;
            mem_raddr = ptr_dec(rd_ptr);
          end
        end else begin
          mem_we = out_free;
        end
      end
      S_INS: begin
        mem_we = out_free;
      end
      default: begin
      end
    endcase
  end

  // result of the step that ends the operation
  always_comb begin
    finish       = 1'b0;
    res_status   = ST_OK;
    res_rem_val  = '0;
    res_rem_pri  = '0;
    res_head_val = head_val;
    res_head_pri = head_pri;
    res_count    = count;
    case (state)
      S_START: begin
        if (req_op == OP_ENQ) begin
          if (count == FULL_CNT) begin
            finish     = out_free;
            res_status = ST_OVERFLOW;
          end else if (count == '0) begin
            finish       = out_free;
            res_head_val = req_val;
            res_head_pri = req_pri;
            res_count    = ONE_CNT;
          end
        end else if (count == '0) begin
          finish       = out_free;
          res_status   = ST_UNDERFLOW;
          res_head_val = '0;
          res_head_pri = '0;
        end else if (count == ONE_CNT) begin
          finish       = out_free;
          res_rem_val  = head_val;
          res_rem_pri  = head_pri;
          res_head_val = '0;
          res_head_pri = '0;
          res_count    = '0;
        end
      end
      S_SCAN: begin
        if (!shift_hit) begin
          finish    = out_free;
          res_count = count + 1'b1;
        end
      end
      S_INS: begin
        finish       = out_free;
        res_head_val = req_val;
        res_head_pri = req_pri;
        res_count    = count + 1'b1;
      end
      S_DEQ: begin
        finish       = out_free;
        res_rem_val  = rem_val;
        res_rem_pri  = rem_pri;
        res_head_val = rd_val;
        res_head_pri = rd_pri;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      hptr      <= '0;
      tptr      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !finish) begin
        out_valid <= 1'b0;
      end
      if (finish) begin
        out_valid        <= 1'b1;
        status           <= res_status;
        removed_value    <= res_rem_val;
        removed_priority <= pri_to_port(res_rem_pri);
        head_value       <= res_head_val;
        head_priority    <= pri_to_port(res_head_pri);
        entry_count      <= COUNT_PORT_W'(res_count);
        state            <= S_IDLE;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_op  <= operation;
            req_val <= item_value;
            req_pri <= in_pri;
            state   <= S_START;
          end
        end
        S_START: begin
          if (req_op == OP_ENQ) begin
            if (count == '0) begin
              if (finish) begin
                head_val <= req_val;
                head_pri <= req_pri;
                count    <= ONE_CNT;
                tptr     <= ptr_inc(tptr);
              end
            end else if (count != FULL_CNT) begin
              rd_ptr <= ptr_dec(tptr);
              wr_ptr <= tptr;
              k      <= count;
              state  <= S_SCAN;
            end
          end else if (count == ONE_CNT) begin
            if (finish) begin
              hptr  <= ptr_inc(hptr);
              count <= '0;
            end
          end else if (count != '0) begin
            rem_val <= head_val;
            rem_pri <= head_pri;
            hptr    <= ptr_inc(hptr);
            count   <= count - 1'b1;
            state   <= S_DEQ;
          end
        end
        S_SCAN: begin
          if (shift_hit) begin
            wr_ptr <= rd_ptr;
            k      <= k - 1'b1;
            if (k == ONE_CNT) begin
              state <= S_INS;
            end else begin
              rd_ptr <= ptr_dec(rd_ptr);
            end
          end else if (finish) begin
            count <= count + 1'b1;
            tptr  <= ptr_inc(tptr);
          end
        end
        S_INS: begin
          if (finish) begin
            head_val <= req_val;
            head_pri <= req_pri;
            count    <= count + 1'b1;
            tptr     <= ptr_inc(tptr);
          end
        end
        S_DEQ: begin
          if (finish) begin
            head_val <= rd_val;
            head_pri <= rd_pri;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("entry count above depth");

  a_empty_ring: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (hptr == tptr))
    else $error("empty queue with head and tail apart");

  a_scan_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (k != '0 && k <= count))
    else $error("scan slot outside live entries");

  a_no_port_clash: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write to the same entry");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state != S_IDLE))
    else $error("result without a request in flight");

endmodule

@@ tb/sorted_array_priority_queue_test.sv @@
// Self-checking testbench for the sorted-array priority queue.
`timescale 1ns / 1ps

module sorted_array_priority_queue_test;
  import sapq_pkg::*;

  // Longest request: enqueue into a full-length shift, plus margin.
  localparam int SETTLE_CYCLES = DEPTH_DEF + 8;
  // Long receiver hold-off used to back the queue up into its input.
  localparam int HOLD_OFF_CYCLES = 400;

  // One result as the block reports it.
  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [VALUE_W-1:0]      removed_value;
    logic [PRI_PORT_W-1:0]   removed_priority;
    logic [VALUE_W-1:0]      head_value;
    logic [PRI_PORT_W-1:0]   head_priority;
    logic [COUNT_PORT_W-1:0] entry_count;
  } outcome_t;

  // One row of directed stimulus. When pinned is set, the typed-in result
  // is what the block must return; otherwise the shadow queue decides.
  typedef struct packed {
    logic                  op;
    logic [VALUE_W-1:0]    val;
    logic [PRI_PORT_W-1:0] pri;
    logic                  pinned;
    outcome_t              want;
  } stim_row_t;

  localparam outcome_t NO_PIN = '0;

  localparam stim_row_t DIRECTED_ROWS [22] = '{
    // Dequeue straight after reset: underflow, everything else zero.
    '{OP_DEQ, 8'h5A, 8'hC3, 1'b1, '{ST_UNDERFLOW, 8'h00, 8'h00, 8'h00, 8'h00, 7'd0}},
    // Extremes of value and priority.
    '{OP_ENQ, 8'hFF, 8'hFF, 1'b1, '{ST_OK, 8'h00, 8'h00, 8'hFF, 8'hFF, 7'd1}},
    '{OP_ENQ, 8'h00, 8'h00, 1'b1, '{ST_OK, 8'h00, 8'h00, 8'h00, 8'h00, 7'd2}},
    // Equal priority at the head: newest entry goes first.
    '{OP_ENQ, 8'hA5, 8'h00, 1'b1, '{ST_OK, 8'h00, 8'h00, 8'hA5, 8'h00, 7'd3}},
    // Equal priority at the tail, then inserts in the middle.
    '{OP_ENQ, 8'h5A, 8'hFF, 1'b0, NO_PIN},
    '{OP_ENQ, 8'h3C, 8'h80, 1'b0, NO_PIN},
    '{OP_ENQ, 8'h81, 8'h01, 1'b0, NO_PIN},
    '{OP_ENQ, 8'h7E, 8'h7F, 1'b0, NO_PIN},
    // Dequeue ignores its payload.
    '{OP_DEQ, 8'hFF, 8'hFF, 1'b0, NO_PIN},
    '{OP_DEQ, 8'h00, 8'h00, 1'b0, NO_PIN},
    '{OP_ENQ, 8'h11, 8'h00, 1'b0, NO_PIN},
    // Drain to empty.
    '{OP_DEQ, 8'hFF, 8'h00, 1'b0, NO_PIN},
    '{OP_DEQ, 8'h00, 8'hFF, 1'b0, NO_PIN},
    '{OP_DEQ, 8'h55, 8'hAA, 1'b0, NO_PIN},
    '{OP_DEQ, 8'hAA, 8'h55, 1'b0, NO_PIN},
    '{OP_DEQ, 8'h0F, 8'hF0, 1'b0, NO_PIN},
    '{OP_DEQ, 8'hF0, 8'h0F, 1'b0, NO_PIN},
    '{OP_DEQ, 8'h01, 8'h80, 1'b1, '{ST_UNDERFLOW, 8'h00, 8'h00, 8'h00, 8'h00, 7'd0}},
    // Single entry in and out, both priority extremes.
    '{OP_ENQ, 8'h00, 8'hFF, 1'b1, '{ST_OK, 8'h00, 8'h00, 8'h00, 8'hFF, 7'd1}},
    '{OP_DEQ, 8'hAA, 8'h55, 1'b1, '{ST_OK, 8'h00, 8'hFF, 8'h00, 8'h00, 7'd0}},
    '{OP_ENQ, 8'hFF, 8'h00, 1'b1, '{ST_OK, 8'h00, 8'h00, 8'hFF, 8'h00, 7'd1}},
    '{OP_DEQ, 8'h00, 8'h00, 1'b1, '{ST_OK, 8'hFF, 8'h00, 8'h00, 8'h00, 7'd0}}
  };

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    operation = OP_ENQ;
  logic [VALUE_W-1:0]      item_value = '0;
  logic [PRI_PORT_W-1:0]   item_priority = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [STATUS_W-1:0]     status;
  logic [VALUE_W-1:0]      removed_value;
  logic [PRI_PORT_W-1:0]   removed_priority;
  logic [VALUE_W-1:0]      head_value;
  logic [PRI_PORT_W-1:0]   head_priority;
  logic [COUNT_PORT_W-1:0] entry_count;

  sorted_array_priority_queue dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .operation        (operation),
    .item_value       (item_value),
    .item_priority    (item_priority),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .removed_value    (removed_value),
    .removed_priority (removed_priority),
    .head_value       (head_value),
    .head_priority    (head_priority),
    .entry_count      (entry_count)
  );

  // Shadow copy of the queue contents, kept sorted by ascending priority.
  logic [VALUE_W-1:0]    shadow_val [DEPTH_DEF];
  logic [PRI_PORT_W-1:0] shadow_pri [DEPTH_DEF];
  int                    shadow_count = 0;

  // Results owed by the block, oldest first.
  outcome_t awaited_outcomes [$];
  int       mismatches = 0;

  // Idle rates in percent, per phase of the run.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int run_phase   = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #8ms;
    $display("FAILURE");
    $finish;
  end

  // Applies one request to the shadow queue and returns the result it owes.
  function automatic outcome_t queue_update(input logic op, input logic [VALUE_W-1:0] v,
                                            input logic [PRI_PORT_W-1:0] p);
    outcome_t o;
    int       k;
    o = '0;
    if (op == OP_ENQ) begin
      if (shadow_count >= DEPTH_DEF) begin
        o.status = ST_OVERFLOW;
      end else begin
        // Everything with priority >= p moves back one slot.
        k = shadow_count;
        while (k > 0 && p <= shadow_pri[k-1]) begin
          shadow_val[k] = shadow_val[k-1];
          shadow_pri[k] = shadow_pri[k-1];
          k--;
        end
        shadow_val[k] = v;
        shadow_pri[k] = p;
        shadow_count++;
        o.status = ST_OK;
      end
    end else if (shadow_count == 0) begin
      o.status = ST_UNDERFLOW;
    end else begin
      o.status           = ST_OK;
      o.removed_value    = shadow_val[0];
      o.removed_priority = shadow_pri[0];
      for (k = 1; k < shadow_count; k++) begin
        shadow_val[k-1] = shadow_val[k];
        shadow_pri[k-1] = shadow_pri[k];
      end
      shadow_count--;
    end
    if (shadow_count > 0) begin
      o.head_value    = shadow_val[0];
      o.head_priority = shadow_pri[0];
    end
    o.entry_count = COUNT_PORT_W'(shadow_count);
    return o;
  endfunction

  // Priority mix: extremes, a narrow band full of ties, the top band, anything.
  function automatic logic [PRI_PORT_W-1:0] rand_priority();
    case ($urandom_range(3))
      0:       return $urandom_range(1) ? 8'hFF : 8'h00;
      1:       return PRI_PORT_W'($urandom_range(7));
      2:       return PRI_PORT_W'($urandom_range(255, 248));
      default: return PRI_PORT_W'($urandom_range(255));
    endcase
  endfunction

  // Offers one request after a random gap and waits for it to be taken.
  // The gap is decided up front so in_valid sees one assignment per step.
  task automatic send_request(input logic op, input logic [VALUE_W-1:0] v,
                              input logic [PRI_PORT_W-1:0] p, input logic pinned,
                              input outcome_t want);
    outcome_t predicted;
    int       gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    item_value    <= v;
    item_priority <= p;
    do @(posedge clk); while (in_stall);
    predicted = queue_update(op, v, p);
    awaited_outcomes.push_back(pinned ? want : predicted);
  endtask

  // Random traffic in bursts: fill past the top, drain past the bottom,
  // or a mixed run. Fills and drains are what reach overflow, underflow
  // and the reuse of the whole depth after dequeues.
  task automatic random_run(input int total);
    int issued;
    int mode;
    int extra;
    int burst;
    logic op;
    issued = 0;
    while (issued < total) begin
      mode = $urandom_range(9);
      if (mode < 2) begin
        extra = $urandom_range(3, 1);
        while (issued < total && (shadow_count < DEPTH_DEF || extra > 0)) begin
          if (shadow_count >= DEPTH_DEF) extra--;
          send_request(OP_ENQ, VALUE_W'($urandom_range(255)), rand_priority(), 1'b0, NO_PIN);
          issued++;
        end
      end else if (mode < 4) begin
        extra = $urandom_range(2, 1);
        while (issued < total && (shadow_count > 0 || extra > 0)) begin
          if (shadow_count == 0) extra--;
          send_request(OP_DEQ, VALUE_W'($urandom_range(255)), rand_priority(), 1'b0, NO_PIN);
          issued++;
        end
      end else begin
        burst = $urandom_range(40, 8);
        while (issued < total && burst > 0) begin
          op = ($urandom_range(99) < 55) ? OP_ENQ : OP_DEQ;
          send_request(op, VALUE_W'($urandom_range(255)), rand_priority(), 1'b0, NO_PIN);
          issued++;
          burst--;
        end
      end
    end
  endtask

  // Receiver: random stalls at the phase rate, plus one long hold-off in the
  // last phase while the sender keeps pushing, so the block backs up.
  initial begin : receiver
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (run_phase == 2 && !hold_done) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // Result checker: every accepted result against the oldest one owed.
  always @(posedge clk) begin : result_check
    outcome_t want;
    outcome_t got;
    if (!rst && out_valid && !out_stall) begin
      got = '{status, removed_value, removed_priority, head_value, head_priority,
              entry_count};
      if (awaited_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no request pending: st=%0d rv=%h rp=%h hv=%h hp=%h n=%0d",
                   $realtime, got.status, got.removed_value, got.removed_priority,
                   got.head_value, got.head_priority, got.entry_count);
      end else begin
        want = awaited_outcomes.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: mismatch, expected st=%0d rv=%h rp=%h hv=%h hp=%h n=%0d",
                     $realtime, want.status, want.removed_value, want.removed_priority,
                     want.head_value, want.head_priority, want.entry_count);
            $display("%0t:          actual   st=%0d rv=%h rp=%h hv=%h hp=%h n=%0d",
                     $realtime, got.status, got.removed_value, got.removed_priority,
                     got.head_value, got.head_priority, got.entry_count);
          end
        end
      end
    end
  end

  // Main sequence: reset, directed table, then three random phases.
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Phase 0: sender idles 36%, receiver 53%.
    tx_idle_pct = 36;
    rx_idle_pct = 53;
    foreach (DIRECTED_ROWS[i])
      send_request(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].val, DIRECTED_ROWS[i].pri,
                   DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].want);
    random_run(470);

    // Phase 1: rates swapped.
    run_phase   = 1;
    tx_idle_pct = 53;
    rx_idle_pct = 36;
    random_run(470);

    // Phase 2: no idling, apart from the receiver's long hold-off.
    run_phase   = 2;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_run(460);

    in_valid <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
    // Catch any stray result after the last one owed.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
